// ===== src/ppmp6_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppmp6_pkg
// Shared types, constants and the parser state record for the P6 header
// parser and its pixel labeling logic.
// ----------------------------------------------------------------------------
package ppmp6_pkg;

  localparam int DIM_BITS = 16;
  localparam int OUT_DIM_BITS = 16;
  localparam int ACC_EXT_BITS = DIM_BITS + 4;
  localparam logic [DIM_BITS-1:0] DIM_LIMIT = {DIM_BITS{1'b1}};

  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_6 = 8'h36;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [DIM_BITS-1:0] MAXVAL_REQUIRED = DIM_BITS'(255);
  localparam logic [1:0] LAST_CHANNEL = 2'd2;

  localparam logic [1:0] NUM_WIDTH = 2'd0;
  localparam logic [1:0] NUM_HEIGHT = 2'd1;
  localparam logic [1:0] NUM_MAXVAL = 2'd2;
  localparam logic [1:0] NUM_DONE = 2'd3;

  typedef enum logic [3:0] {
    PH_MAGIC_P    = 4'd0,
    PH_MAGIC_6    = 4'd1,
    PH_MAGIC_WS   = 4'd2,
    PH_SKIP_WS    = 4'd3,
    PH_DIGITS     = 4'd4,
    PH_DATA       = 4'd5,
    PH_EXPECT_EOF = 4'd6,
    PH_DONE       = 4'd7,
    PH_FAILED     = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    EV_HEADER   = 3'd0,
    EV_PIXEL    = 3'd1,
    EV_COMPLETE = 3'd2,
    EV_ERROR    = 3'd3,
    EV_IGNORED  = 3'd4
  } event_t;

  typedef struct packed {
    phase_t                phase;
    logic [1:0]            number_index;
    logic [DIM_BITS-1:0]   accumulator;
    logic [DIM_BITS-1:0]   width_reg;
    logic [DIM_BITS-1:0]   height_reg;
    logic [1:0]            channel_count;
    logic [DIM_BITS-1:0]   column_count;
    logic [DIM_BITS-1:0]   row_count;
  } parse_state_t;

  localparam parse_state_t STATE_START = '{
    phase:         PH_MAGIC_P,
    number_index:  NUM_WIDTH,
    accumulator:   '0,
    width_reg:     '0,
    height_reg:    '0,
    channel_count: 2'd0,
    column_count:  '0,
    row_count:     '0
  };

  typedef struct packed {
    event_t                  event_res;
    logic [7:0]              pixel_value;
    logic [1:0]              channel;
    logic [OUT_DIM_BITS-1:0] column;
    logic [OUT_DIM_BITS-1:0] row;
    logic [OUT_DIM_BITS-1:0] image_width;
    logic [OUT_DIM_BITS-1:0] image_height;
  } parse_result_t;

endpackage
`default_nettype wire

// ===== src/ppmp6_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppmp6_step
// Combinational next-state and result logic for one byte or end-of-file
// transaction of the P6 parser.
// ----------------------------------------------------------------------------
module ppmp6_step (
  input  wire ppmp6_pkg::parse_state_t  state_cur,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     end_of_file,
  input  wire logic                     new_file,
  output ppmp6_pkg::parse_state_t       state_nxt,
  output ppmp6_pkg::parse_result_t      result
);

  ppmp6_pkg::parse_state_t cur;
  ppmp6_pkg::event_t       ev;
  logic                    is_ws;
  logic                    is_digit;
  logic [3:0]              digit;
  logic [ppmp6_pkg::ACC_EXT_BITS-1:0] acc_ext;
  logic [ppmp6_pkg::DIM_BITS:0]       col_inc;
  logic [ppmp6_pkg::DIM_BITS:0]       row_inc;

  assign cur = new_file ? ppmp6_pkg::STATE_START : state_cur;
  assign is_ws = (data_byte == ppmp6_pkg::CHAR_SPACE) ||
                 (data_byte inside {[ppmp6_pkg::CHAR_TAB:ppmp6_pkg::CHAR_CR]});
  assign is_digit = data_byte inside {[ppmp6_pkg::CHAR_0:ppmp6_pkg::CHAR_9]};
  assign digit = 4'(data_byte - ppmp6_pkg::CHAR_0);
  assign acc_ext = (ppmp6_pkg::ACC_EXT_BITS'(cur.accumulator) << 3) +
                   (ppmp6_pkg::ACC_EXT_BITS'(cur.accumulator) << 1) +
                   ppmp6_pkg::ACC_EXT_BITS'(digit);
  assign col_inc = {1'b0, cur.column_count} + 1'b1;
  assign row_inc = {1'b0, cur.row_count} + 1'b1;

  always_comb begin
    state_nxt = cur;
    ev = ppmp6_pkg::EV_HEADER;
    result = '0;
    if (cur.phase == ppmp6_pkg::PH_DONE || cur.phase == ppmp6_pkg::PH_FAILED) begin
      ev = ppmp6_pkg::EV_IGNORED;
    end else if (end_of_file) begin
      if (cur.phase == ppmp6_pkg::PH_EXPECT_EOF) begin
        state_nxt.phase = ppmp6_pkg::PH_DONE;
        ev = ppmp6_pkg::EV_COMPLETE;
      end else begin
        state_nxt.phase = ppmp6_pkg::PH_FAILED;
        ev = ppmp6_pkg::EV_ERROR;
      end
    end else begin
      case (cur.phase)
        ppmp6_pkg::PH_MAGIC_P: begin
          if (data_byte == ppmp6_pkg::CHAR_P) begin
            state_nxt.phase = ppmp6_pkg::PH_MAGIC_6;
          end else begin
            state_nxt.phase = ppmp6_pkg::PH_FAILED;
            ev = ppmp6_pkg::EV_ERROR;
          end
        end
        ppmp6_pkg::PH_MAGIC_6: begin
          if (data_byte == ppmp6_pkg::CHAR_6) begin
            state_nxt.phase = ppmp6_pkg::PH_MAGIC_WS;
          end else begin
            state_nxt.phase = ppmp6_pkg::PH_FAILED;
            ev = ppmp6_pkg::EV_ERROR;
          end
        end
        ppmp6_pkg::PH_MAGIC_WS: begin
          if (is_ws) begin
            state_nxt.phase = ppmp6_pkg::PH_SKIP_WS;
          end else begin
            state_nxt.phase = ppmp6_pkg::PH_FAILED;
            ev = ppmp6_pkg::EV_ERROR;
          end
        end
        ppmp6_pkg::PH_SKIP_WS: begin
          if (is_digit) begin
            state_nxt.accumulator = ppmp6_pkg::DIM_BITS'(digit);
            state_nxt.phase = ppmp6_pkg::PH_DIGITS;
          end else if (!is_ws) begin
            state_nxt.phase = ppmp6_pkg::PH_FAILED;
            ev = ppmp6_pkg::EV_ERROR;
          end
        end
        ppmp6_pkg::PH_DIGITS: begin
          if (is_digit) begin
            if (acc_ext > ppmp6_pkg::ACC_EXT_BITS'(ppmp6_pkg::DIM_LIMIT)) begin
              state_nxt.phase = ppmp6_pkg::PH_FAILED;
              ev = ppmp6_pkg::EV_ERROR;
            end else begin
              state_nxt.accumulator = acc_ext[ppmp6_pkg::DIM_BITS-1:0];
            end
          end else if (is_ws) begin
            state_nxt.accumulator = '0;
            case (cur.number_index)
              ppmp6_pkg::NUM_WIDTH: begin
                state_nxt.width_reg = cur.accumulator;
                state_nxt.number_index = ppmp6_pkg::NUM_HEIGHT;
                state_nxt.phase = ppmp6_pkg::PH_SKIP_WS;
              end
              ppmp6_pkg::NUM_HEIGHT: begin
                state_nxt.height_reg = cur.accumulator;
                state_nxt.number_index = ppmp6_pkg::NUM_MAXVAL;
                state_nxt.phase = ppmp6_pkg::PH_SKIP_WS;
              end
              default: begin
                if (cur.accumulator != ppmp6_pkg::MAXVAL_REQUIRED) begin
                  state_nxt.accumulator = cur.accumulator;
                  state_nxt.phase = ppmp6_pkg::PH_FAILED;
                  ev = ppmp6_pkg::EV_ERROR;
                end else begin
                  state_nxt.number_index = ppmp6_pkg::NUM_DONE;
                  state_nxt.channel_count = 2'd0;
                  state_nxt.column_count = '0;
                  state_nxt.row_count = '0;
                  state_nxt.phase = (cur.width_reg == '0 || cur.height_reg == '0) ?
                                    ppmp6_pkg::PH_EXPECT_EOF : ppmp6_pkg::PH_DATA;
                end
              end
            endcase
          end else begin
            state_nxt.phase = ppmp6_pkg::PH_FAILED;
            ev = ppmp6_pkg::EV_ERROR;
          end
        end
        ppmp6_pkg::PH_DATA: begin
          ev = ppmp6_pkg::EV_PIXEL;
          result.pixel_value = data_byte;
          result.channel = cur.channel_count;
          result.column = ppmp6_pkg::OUT_DIM_BITS'(cur.column_count);
          result.row = ppmp6_pkg::OUT_DIM_BITS'(cur.row_count);
          if (cur.channel_count < ppmp6_pkg::LAST_CHANNEL) begin
            state_nxt.channel_count = cur.channel_count + 2'd1;
          end else begin
            state_nxt.channel_count = 2'd0;
            if (col_inc < {1'b0, cur.width_reg}) begin
              state_nxt.column_count = col_inc[ppmp6_pkg::DIM_BITS-1:0];
            end else begin
              state_nxt.column_count = '0;
              if (row_inc < {1'b0, cur.height_reg}) begin
                state_nxt.row_count = row_inc[ppmp6_pkg::DIM_BITS-1:0];
              end else begin
                state_nxt.phase = ppmp6_pkg::PH_EXPECT_EOF;
              end
            end
          end
        end
        default: begin
          state_nxt.phase = ppmp6_pkg::PH_FAILED;
          ev = ppmp6_pkg::EV_ERROR;
        end
      endcase
    end
    result.event_res = ev;
    result.image_width = ppmp6_pkg::OUT_DIM_BITS'(state_nxt.width_reg);
    result.image_height = ppmp6_pkg::OUT_DIM_BITS'(state_nxt.height_reg);
  end

endmodule
`default_nettype wire

// ===== src/ppm_p6_stream_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser_core
// Parses a P6 image file arriving one byte per transaction and labels each
// pixel byte with its channel, column and row.
//
// The input channel carries one file byte per transaction in in_tdata, with
// in_tlast marking end of file (no byte carried) and in_tuser restarting the
// parser so that the transaction is the first of a new file.
// Every input transaction yields exactly one output transaction: an event
// code in out_tuser and the pixel labels and parsed dimensions in out_tdata.
// An accepted transaction sits in the input register while the parse step
// runs, and its result moves into the output register once that register is
// empty or being drained, which raises out_tvalid.
// Throughput is one transaction per cycle while out_tready stays high; the parse
// state is updated in the same cycle the result is registered, so consecutive
// bytes follow directly. When the receiver stalls, the output register holds its
// result and the input register fills; in_tready drops only when both are occupied.
// After reset both registers are empty and the parser waits for the magic P.
// ----------------------------------------------------------------------------
module ppm_p6_stream_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_file
  input  wire logic        in_tuser,   // new_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [7:0] pixel_value, [9:8] channel,
                                       // [25:10] column, [41:26] row,
                                       // [57:42] image_width,
                                       // [73:58] image_height, [79:74] zero
  output logic [2:0]       out_tuser   // [2:0] event_res
);

  logic                      in_valid_r;
  logic [7:0]                in_data_r;
  logic                      in_eof_r;
  logic                      in_new_r;
  logic                      out_valid_r;
  ppmp6_pkg::parse_result_t  out_res_r;
  ppmp6_pkg::parse_state_t   state_r;
  ppmp6_pkg::parse_state_t   state_nxt;
  ppmp6_pkg::parse_result_t  res_nxt;
  logic                      advance;
  logic                      fire;

  assign advance = !out_valid_r || out_tready;
  assign fire = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  ppmp6_step u_step (
    .state_cur   (state_r),
    .data_byte   (in_data_r),
    .end_of_file (in_eof_r),
    .new_file    (in_new_r),
    .state_nxt   (state_nxt),
    .result      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_eof_r <= in_tlast;
      in_new_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppmp6_pkg::STATE_START;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        state_r <= state_nxt;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_res_r.event_res;
  assign out_tdata = {6'd0, out_res_r.image_height, out_res_r.image_width,
                      out_res_r.row, out_res_r.column, out_res_r.channel,
                      out_res_r.pixel_value};

  a_pixel_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.event_res == ppmp6_pkg::EV_PIXEL |->
      out_res_r.channel <= ppmp6_pkg::LAST_CHANNEL &&
      out_res_r.column < out_res_r.image_width &&
      out_res_r.row < out_res_r.image_height)
    else $error("pixel label outside the parsed image");

  a_no_label_off_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.event_res != ppmp6_pkg::EV_PIXEL |->
      out_res_r.pixel_value == 8'd0 && out_res_r.channel == 2'd0 &&
      out_res_r.column == '0 && out_res_r.row == '0)
    else $error("pixel fields set on a non-pixel event");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_res_r))
    else $error("stalled result changed");

  a_state_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("parser state changed without a transaction");

  a_terminal_ignores: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !in_new_r &&
    (state_r.phase == ppmp6_pkg::PH_DONE || state_r.phase == ppmp6_pkg::PH_FAILED) |=>
      out_res_r.event_res == ppmp6_pkg::EV_IGNORED)
    else $error("terminal state did not ignore the transaction");

endmodule
`default_nettype wire
